>>> rtl/arpc_pkg.sv
// Shared types and constants for the ARP cache with LRU replacement.
// No dependencies; imported by arpc_front, arpc_engine and the top level.
`default_nettype none
package arpc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ENTER  = 3'd1;
  localparam logic [2:0] OP_PERM   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    K_LOOKUP,
    K_ENTER,
    K_PERM,
    K_DELETE,
    K_FLUSH,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] ip;
    logic [47:0] mac;
  } cmd_t;

  // queue head as seen by the engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage
`default_nettype wire

>>> rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module arpc_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/arpc_front.sv
// Front end: accepts transactions, classifies the op code, queues commands.
// Depends on arpc_pkg.
`default_nettype none
module arpc_front
  import arpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_ip_addr,
  input  wire logic [47:0] in_mac_in,
  output qhead_t           head,
  input  wire logic        pop
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cmd;
  logic              push;

  always_comb begin
    cmd.ip  = in_ip_addr;
    cmd.mac = in_mac_in;
    unique case (in_op)
      OP_LOOKUP: cmd.kind = K_LOOKUP;
      OP_ENTER:  cmd.kind = K_ENTER;
      OP_PERM:   cmd.kind = K_PERM;
      OP_DELETE: cmd.kind = K_DELETE;
      OP_FLUSH:  cmd.kind = K_FLUSH;
      default:   cmd.kind = K_BAD;
    endcase
  end

  assign busy = (cnt_r == QCNT_W'(QDEPTH));
  assign push = start && !busy;

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop && head.valid) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop && head.valid);
    end
  end

endmodule
`default_nettype wire

>>> rtl/arpc_engine.sv
// Back end: scans the table, applies the command, updates recency ranks.
// Depends on arpc_pkg and arpc_ram.
`default_nettype none
module arpc_engine
  import arpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qhead_t head,
  output logic        pop,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [47:0] out_mac_out,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_MACRD,
    S_SWEEP
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [IDX_W-1:0]   frank_r, frank_nxt;
  logic               cand_r, cand_nxt;
  logic [IDX_W-1:0]   cidx_r, cidx_nxt;
  logic [IDX_W-1:0]   crank_r, crank_nxt;
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  logic [IDX_W-1:0]   trank_r, trank_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] perm_r, perm_nxt;
  logic [ENTRIES-1:0] rset_r, rset_nxt;
  logic [31:0]        hits_r, hits_nxt;
  logic [31:0]        misses_r, misses_nxt;
  logic               strobe_r, strobe_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [47:0]        mac_r, mac_nxt;

  logic               ip_we, mac_we, rank_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rank_wdata;
  logic [31:0]        ip_rdata;
  logic [47:0]        mac_rdata;
  logic [IDX_W-1:0]   rank_rdata;
  logic [IDX_W-1:0]   rank_cur;
  logic               last;

  arpc_ram #(.W(32), .D(ENTRIES)) u_ip_ram (
    .clk(clk), .we(ip_we), .waddr(wr_idx), .wdata(cmd_r.ip),
    .raddr(cnt_r[IDX_W-1:0]), .rdata(ip_rdata)
  );

  arpc_ram #(.W(48), .D(ENTRIES)) u_mac_ram (
    .clk(clk), .we(mac_we), .waddr(wr_idx), .wdata(cmd_r.mac),
    .raddr(fidx_r), .rdata(mac_rdata)
  );

  arpc_ram #(.W(IDX_W), .D(ENTRIES)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rd_idx_r), .wdata(rank_wdata),
    .raddr(cnt_r[IDX_W-1:0]), .rdata(rank_rdata)
  );

  // rank of an entry never swept since reset is its own index
  assign rank_cur = rset_r[rd_idx_r] ? rank_rdata : rd_idx_r;
  assign last     = rd_vld_r && (rd_idx_r == IDX_W'(ENTRIES - 1));

  assign rank_wdata = (rd_idx_r == tgt_r) ? '0 :
                      (rank_cur < trank_r) ? rank_cur + IDX_W'(1) : rank_cur;
  assign rank_we = (state_r == S_SWEEP) && rd_vld_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    cnt_nxt    = cnt_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    frank_nxt  = frank_r;
    cand_nxt   = cand_r;
    cidx_nxt   = cidx_r;
    crank_nxt  = crank_r;
    tgt_nxt    = tgt_r;
    trank_nxt  = trank_r;
    valid_nxt  = valid_r;
    perm_nxt   = perm_r;
    rset_nxt   = rset_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    mac_nxt    = mac_r;
    pop        = 1'b0;
    ip_we      = 1'b0;
    mac_we     = 1'b0;
    wr_idx     = fidx_r;

    // read issue shared by scan and sweep
    if ((state_r == S_SCAN || state_r == S_SWEEP) && cnt_r < CNT_W'(ENTRIES)) begin
      cnt_nxt    = cnt_r + CNT_W'(1);
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = cnt_r[IDX_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          cmd_nxt   = head.cmd;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          cand_nxt  = 1'b0;
          mac_nxt   = '0;
          unique case (head.cmd.kind)
            K_FLUSH: begin
              valid_nxt  = '0;
              perm_nxt   = '0;
              strobe_nxt = 1'b1;
              status_nxt = ST_OK;
            end
            K_BAD: begin
              strobe_nxt = 1'b1;
              status_nxt = ST_MISS;
            end
            default: state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          if (!found_r && valid_r[rd_idx_r] && ip_rdata == cmd_r.ip) begin
            found_nxt = 1'b1;
            fidx_nxt  = rd_idx_r;
            frank_nxt = rank_cur;
          end
          if ((!valid_r[rd_idx_r] || !perm_r[rd_idx_r]) &&
              (!cand_r || rank_cur > crank_r)) begin
            cand_nxt  = 1'b1;
            cidx_nxt  = rd_idx_r;
            crank_nxt = rank_cur;
          end
        end
        if (last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = found_r ? ST_OK : ST_MISS;
        unique case (cmd_r.kind)
          K_LOOKUP: begin
            if (found_r) begin
              strobe_nxt = 1'b0;
              state_nxt  = S_MACRD;
            end else begin
              misses_nxt = misses_r + 32'd1;
            end
          end
          K_ENTER: begin
            status_nxt = ST_OK;
            if (found_r) begin
              mac_we = !perm_r[fidx_r];
            end else if (cand_r) begin
              wr_idx            = cidx_r;
              ip_we             = 1'b1;
              mac_we            = 1'b1;
              valid_nxt[cidx_r] = 1'b1;
              perm_nxt[cidx_r]  = 1'b0;
              tgt_nxt           = cidx_r;
              trank_nxt         = crank_r;
              cnt_nxt           = '0;
              strobe_nxt        = 1'b0;
              state_nxt         = S_SWEEP;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          K_PERM: begin
            if (found_r) begin
              perm_nxt[fidx_r] = 1'b1;
            end
          end
          K_DELETE: begin
            if (found_r) begin
              valid_nxt[fidx_r] = 1'b0;
              perm_nxt[fidx_r]  = 1'b0;
            end
          end
          default: begin
            status_nxt = ST_MISS;
          end
        endcase
      end
      S_MACRD: begin
        mac_nxt   = mac_rdata;
        tgt_nxt   = fidx_r;
        trank_nxt = frank_r;
        cnt_nxt   = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (rd_vld_r) begin
          rset_nxt[rd_idx_r] = 1'b1;
        end
        if (last) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          if (cmd_r.kind == K_LOOKUP) begin
            hits_nxt = hits_r + 32'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    rd_idx_r <= rd_idx_nxt;
    fidx_r   <= fidx_nxt;
    frank_r  <= frank_nxt;
    cidx_r   <= cidx_nxt;
    crank_r  <= crank_nxt;
    tgt_r    <= tgt_nxt;
    trank_r  <= trank_nxt;
    status_r <= status_nxt;
    mac_r    <= mac_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      cand_r   <= 1'b0;
      valid_r  <= '0;
      perm_r   <= '0;
      rset_r   <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
      cand_r   <= cand_nxt;
      valid_r  <= valid_nxt;
      perm_r   <= perm_nxt;
      rset_r   <= rset_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_mac_out    = mac_r;
  assign out_hit_count  = hits_r;
  assign out_miss_count = misses_r;

  a_hits_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && hits_r != $past(hits_r) |-> hits_r == $past(hits_r) + 32'd1)
    else $error("hit counter jumped");

  a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && hits_r != $past(hits_r) |-> misses_r == $past(misses_r))
    else $error("hit and miss counted together");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> state_r == S_IDLE)
    else $error("result issued while engine busy");

  a_perm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (perm_r & ~valid_r) == '0)
    else $error("permanent mark on a free entry");

endmodule
`default_nettype wire

>>> rtl/arp_cache_lru.sv
// ARP cache with LRU replacement, top level.
// Depends on arpc_pkg, arpc_front, arpc_engine.
//
// One transaction is taken when start is high and busy is low; a two-deep
// command queue lets the next transactions be taken while one is at work.
// Every transaction gives one result, shown for exactly one cycle with
// out_strobe high; the receiver cannot hold results off. Flush and unused
// op codes finish without reading the table. Lookup, enter, make-permanent
// and delete read the 64-entry table one entry a cycle through the address
// RAM; a lookup hit or an enter that stores a new entry adds a second pass
// over the recency-rank RAM. Results leave in the order the transactions
// were taken.
`default_nettype none
module arp_cache_lru
  import arpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_ip_addr,
  input  wire logic [47:0] in_mac_in,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [47:0]      out_mac_out,
  output logic [31:0]      out_hit_count,
  output logic [31:0]      out_miss_count
);

  qhead_t head;
  logic   pop;

  arpc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_ip_addr(in_ip_addr), .in_mac_in(in_mac_in),
    .head(head), .pop(pop)
  );

  arpc_engine u_engine (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_mac_out(out_mac_out), .out_hit_count(out_hit_count),
    .out_miss_count(out_miss_count)
  );

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench for arp_cache_lru: directed and random table operations.
// Each result is checked field by field against an in-bench LRU table model.
// Depends on arpc_pkg and the arp_cache_lru RTL.
`timescale 1ns / 100ps
module testbench;
  import arpc_pkg::*;

  localparam int WDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;
  localparam int POOL_SIZE = 80;

  typedef struct {
    logic [1:0]  status;
    logic [47:0] mac;
    logic [31:0] hits;
    logic [31:0] misses;
  } arp_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_op;
  logic [31:0] in_ip_addr;
  logic [47:0] in_mac_in;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [47:0] out_mac_out;
  logic [31:0] out_hit_count;
  logic [31:0] out_miss_count;

  // table model
  bit          tbl_valid[ENTRIES];
  bit          tbl_perm[ENTRIES];
  logic [31:0] tbl_ip[ENTRIES];
  logic [47:0] tbl_mac[ENTRIES];
  int          tbl_rank[ENTRIES];
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  arp_result_t pending_results[$];
  logic [31:0] ip_pool[POOL_SIZE];
  int          errors;
  int          idle_pct;
  int          quiet_cycles;

  arp_cache_lru dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_ip_addr(in_ip_addr), .in_mac_in(in_mac_in),
    .out_strobe(out_strobe), .out_status(out_status), .out_mac_out(out_mac_out),
    .out_hit_count(out_hit_count), .out_miss_count(out_miss_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int find_entry(logic [31:0] ip);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void promote(int idx);
    int r;
    r = tbl_rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_rank[i] < r) tbl_rank[i]++;
    tbl_rank[idx] = 0;
  endfunction

  function automatic arp_result_t resolve_op(logic [2:0] op, logic [31:0] ip,
                                             logic [47:0] mac);
    arp_result_t res;
    int idx;
    res.status = ST_MISS;
    res.mac = '0;
    idx = -1;
    case (op)
      OP_LOOKUP: begin
        idx = find_entry(ip);
        if (idx >= 0) begin
          res.mac = tbl_mac[idx];
          promote(idx);
          hit_total++;
          res.status = ST_OK;
        end else begin
          miss_total++;
        end
      end
      OP_ENTER: begin
        idx = find_entry(ip);
        if (idx >= 0) begin
          if (!tbl_perm[idx]) tbl_mac[idx] = mac;
          res.status = ST_OK;
        end else begin
          // victim: replaceable entry with the oldest rank
          for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i] || !tbl_perm[i])
              if (idx < 0 || tbl_rank[i] > tbl_rank[idx]) idx = i;
          if (idx < 0) begin
            res.status = ST_FULL;
          end else begin
            tbl_valid[idx] = 1;
            tbl_perm[idx] = 0;
            tbl_ip[idx] = ip;
            tbl_mac[idx] = mac;
            promote(idx);
            res.status = ST_OK;
          end
        end
      end
      OP_PERM: begin
        idx = find_entry(ip);
        if (idx >= 0) begin
          tbl_perm[idx] = 1;
          res.status = ST_OK;
        end
      end
      OP_DELETE: begin
        idx = find_entry(ip);
        if (idx >= 0) begin
          tbl_valid[idx] = 0;
          tbl_perm[idx] = 0;
          res.status = ST_OK;
        end
      end
      OP_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_valid[i] = 0;
          tbl_perm[i] = 0;
        end
        res.status = ST_OK;
      end
      default: res.status = ST_MISS;
    endcase
    res.hits = hit_total;
    res.misses = miss_total;
    return res;
  endfunction

  // start stays high across back-to-back transactions
  task automatic send_op(logic [2:0] op, logic [31:0] ip, logic [47:0] mac);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_ip_addr <= ip;
    in_mac_in <= mac;
    do @(posedge clk); while (busy);
    pending_results.push_back(resolve_op(op, ip, mac));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_mac();
    logic [47:0] m;
    m[47:32] = 16'($urandom);
    m[31:0] = $urandom;
    return m;
  endfunction

  task automatic test_basic_ops();
    send_op(OP_LOOKUP, 32'h0, '0);
    send_op(OP_ENTER, 32'h0, 48'h0);
    send_op(OP_ENTER, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_op(OP_LOOKUP, 32'h0, '0);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    send_op(OP_ENTER, 32'h0, 48'hA5A5_5A5A_C3C3);
    send_op(OP_LOOKUP, 32'h0, '0);
    send_op(OP_PERM, 32'h0, '0);
    send_op(OP_ENTER, 32'h0, 48'h1234_5678_9ABC);  // permanent: MAC kept
    send_op(OP_LOOKUP, 32'h0, '0);
    send_op(OP_PERM, 32'h0A00_0001, '0);
    send_op(OP_DELETE, 32'h0A00_0001, '0);
    send_op(OP_DELETE, 32'h0, '0);
    send_op(OP_LOOKUP, 32'h0, '0);
    send_op(3'd5, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_op(3'd6, 32'h0, '0);
    send_op(3'd7, 32'hFFFF_FFFF, '0);
    send_op(OP_FLUSH, 32'h0, '0);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    send_op(OP_ENTER, 32'h0, 48'h0);  // deleted entry must not still be permanent
    send_op(OP_ENTER, 32'h0, 48'h5);
    send_op(OP_LOOKUP, 32'h0, '0);
  endtask

  // fill the table with permanent entries until enter reports full
  task automatic test_full_table();
    send_op(OP_FLUSH, '0, '0);
    for (int i = 0; i < ENTRIES; i++) begin
      send_op(OP_ENTER, 32'hC0A8_0000 + i, rand_mac());
      send_op(OP_PERM, 32'hC0A8_0000 + i, '0);
    end
    send_op(OP_ENTER, 32'h0102_0304, rand_mac());
    send_op(OP_LOOKUP, 32'hC0A8_0005, '0);
    send_op(OP_DELETE, 32'hC0A8_0007, '0);
    send_op(OP_ENTER, 32'h0102_0304, rand_mac());
    send_op(OP_ENTER, 32'h0102_0305, rand_mac());
    send_op(OP_FLUSH, '0, '0);
  endtask

  task automatic test_random_mix(int count);
    int pick;
    logic [2:0] op;
    logic [31:0] ip;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) op = OP_LOOKUP;
      else if (pick < 70) op = OP_ENTER;
      else if (pick < 78) op = OP_PERM;
      else if (pick < 90) op = OP_DELETE;
      else if (pick < 92) op = OP_FLUSH;
      else op = 3'($urandom_range(7, 5));
      ip = ($urandom_range(19) == 0) ? 32'($urandom) : ip_pool[$urandom_range(POOL_SIZE - 1)];
      send_op(op, ip, rand_mac());
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    arp_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_mac_out !== want.mac) begin
          $error("mac_out: expected %h, got %h", want.mac, out_mac_out);
          errors++;
        end
        if (out_hit_count !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, out_hit_count);
          errors++;
        end
        if (out_miss_count !== want.misses) begin
          $error("miss_count: expected %0d, got %0d", want.misses, out_miss_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    idle_pct = 6;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_LOOKUP;
    in_ip_addr = '0;
    in_mac_in = '0;
    hit_total = '0;
    miss_total = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 0;
      tbl_perm[i] = 0;
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
      tbl_rank[i] = i;
    end
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_table();
    test_random_mix(200);
    wait_drained();
    idle_pct = 53;
    test_random_mix(200);
    idle_pct = 0;
    test_random_mix(200);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
